/* sv/twdsc_pkg.sv */
package twdsc_pkg;

  // configuration port geometry
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_MIN_GREEN   = 2'd0;
  localparam logic [1:0] REG_YELLOW_TIME = 2'd1;
  localparam logic [1:0] REG_HOLD_GREEN  = 2'd2;
  localparam logic [1:0] REG_UNUSED      = 2'd3;

  // register reset values
  localparam logic [7:0] MIN_GREEN_RST   = 8'd15;
  localparam logic [7:0] YELLOW_TIME_RST = 8'd5;
  localparam logic [7:0] HOLD_GREEN_RST  = 8'd15;

  // item kinds carried on tuser
  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_PRESS = 1'b1;

  // lane code for no lane
  localparam logic [1:0] LANE_NONE = 2'd3;

  // lamp codes
  localparam logic [1:0] LAMP_RED    = 2'd0;
  localparam logic [1:0] LAMP_YELLOW = 2'd1;
  localparam logic [1:0] LAMP_GREEN  = 2'd2;

  localparam logic [7:0] SECS_MAX = 8'hff;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_TOPUP   = 3'd1,
    PH_YELLOW1 = 3'd2,
    PH_HOLD1   = 3'd3,
    PH_YELLOW2 = 3'd4,
    PH_HOLD2   = 3'd5
  } phase_e;

  typedef logic [2:0][1:0] lamps_t;

  typedef struct packed {
    logic [7:0] min_green;
    logic [7:0] yellow_time;
    logic [7:0] hold_green;
  } cfg_t;

  typedef struct packed {
    logic [1:0] active_lane;
    logic [2:0] pending;
    logic [1:0] latest_req;
    phase_e     phase;
    logic [7:0] phase_left;
    logic [7:0] idle_secs;
    logic [1:0] chosen_lane;
    logic       several;
    logic [1:0] second_target;
    lamps_t     prev_lamps;
  } ctl_t;

  localparam ctl_t CTL_RESET = '{
    active_lane:   2'd0,
    pending:       3'b000,
    latest_req:    LANE_NONE,
    phase:         PH_IDLE,
    phase_left:    8'd0,
    idle_secs:     8'd0,
    chosen_lane:   2'd0,
    several:       1'b0,
    second_target: LANE_NONE,
    prev_lamps:    {LAMP_RED, LAMP_RED, LAMP_RED}
  };

  // lamps shown in the current phase
  function automatic lamps_t lamps_now(ctl_t s);
    lamps_t     l;
    logic [1:0] other;
    l = {LAMP_RED, LAMP_RED, LAMP_RED};
    other = (s.phase == PH_YELLOW1) ? s.chosen_lane : s.second_target;
    if (s.phase == PH_YELLOW1 || s.phase == PH_YELLOW2) begin
      if (s.active_lane != LANE_NONE) l[s.active_lane] = LAMP_YELLOW;
      if (other != LANE_NONE) l[other] = LAMP_YELLOW;
    end else if (s.active_lane != LANE_NONE) begin
      l[s.active_lane] = LAMP_GREEN;
    end
    return l;
  endfunction

  // enter a phase; an empty phase still counts as completed
  function automatic ctl_t begin_phase(ctl_t s, phase_e p, logic [7:0] len);
    ctl_t r;
    r = s;
    r.phase = p;
    r.phase_left = len;
    if (len == 8'd0) r.prev_lamps = lamps_now(r);
    return r;
  endfunction

  // pick the next lane to serve, or keep the idle green
  function automatic ctl_t decide(ctl_t s, cfg_t c);
    ctl_t       r;
    logic [2:0] req;
    r = s;
    req = s.pending & ~(3'b001 << s.active_lane);
    if (req == 3'b000) begin
      if (r.idle_secs != SECS_MAX) r.idle_secs = r.idle_secs + 8'd1;
      r = begin_phase(r, PH_IDLE, 8'd1);
    end else begin
      r.several = (req[0] & req[1]) | (req[0] & req[2]) | (req[1] & req[2]);
      r.chosen_lane = req[0] ? 2'd0 : (req[1] ? 2'd1 : 2'd2);
      if (r.idle_secs < c.min_green) begin
        r = begin_phase(r, PH_TOPUP, c.min_green - r.idle_secs);
      end else begin
        r = begin_phase(r, PH_YELLOW1, c.yellow_time);
      end
    end
    return r;
  endfunction

  // one phase change
  function automatic ctl_t advance(ctl_t s, cfg_t c);
    ctl_t r;
    r = s;
    case (s.phase)
      PH_TOPUP: begin
        r = begin_phase(r, PH_YELLOW1, c.yellow_time);
      end
      PH_YELLOW1: begin
        r.active_lane = s.chosen_lane;
        r.pending = s.pending & ~(3'b001 << s.chosen_lane);
        r = begin_phase(r, PH_HOLD1, c.hold_green);
      end
      PH_HOLD1: begin
        if (s.several) begin
          r.second_target = s.latest_req;
          r = begin_phase(r, PH_YELLOW2, c.yellow_time);
        end else begin
          r.idle_secs = 8'd0;
          r = decide(r, c);
        end
      end
      PH_YELLOW2: begin
        if (s.second_target != LANE_NONE) begin
          r.active_lane = s.second_target;
          r.pending = s.pending & ~(3'b001 << s.second_target);
          r = begin_phase(r, PH_HOLD2, c.hold_green);
        end else begin
          r.idle_secs = 8'd0;
          r = decide(r, c);
        end
      end
      PH_HOLD2: begin
        r.idle_secs = 8'd0;
        r = decide(r, c);
      end
      default: begin
        r = decide(r, c);
      end
    endcase
    return r;
  endfunction

endpackage

/* sv/twdsc_cfg_regs.sv */
module twdsc_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [twdsc_pkg::PADDR_W-1:0] paddr,
  input  logic [twdsc_pkg::PDATA_W-1:0] pwdata,
  output logic [twdsc_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output twdsc_pkg::cfg_t              cfg_o
);

  twdsc_pkg::cfg_t cfg_q;
  logic            wr_en;
  logic [1:0]      reg_idx;
  logic [7:0]      rd_val;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  // register writes, data truncated to 8 bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_green   <= twdsc_pkg::MIN_GREEN_RST;
      cfg_q.yellow_time <= twdsc_pkg::YELLOW_TIME_RST;
      cfg_q.hold_green  <= twdsc_pkg::HOLD_GREEN_RST;
    end else if (wr_en) begin
      case (reg_idx)
        twdsc_pkg::REG_MIN_GREEN:   cfg_q.min_green   <= pwdata[7:0];
        twdsc_pkg::REG_YELLOW_TIME: cfg_q.yellow_time <= pwdata[7:0];
        twdsc_pkg::REG_HOLD_GREEN:  cfg_q.hold_green  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      twdsc_pkg::REG_MIN_GREEN:   rd_val = cfg_q.min_green;
      twdsc_pkg::REG_YELLOW_TIME: rd_val = cfg_q.yellow_time;
      twdsc_pkg::REG_HOLD_GREEN:  rd_val = cfg_q.hold_green;
      default:                    rd_val = 8'd0;
    endcase
  end

  assign prdata = {{(twdsc_pkg::PDATA_W-8){1'b0}}, rd_val};
  assign cfg_o  = cfg_q;

endmodule

/* sv/twdsc_core.sv */
module twdsc_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  twdsc_pkg::cfg_t cfg_i,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [7:0]      s_axis_tdata,   // [1:0] lane, rest zero
  input  logic            s_axis_tuser,   // [0] mode
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [15:0]     m_axis_tdata    // lamps, gates, serving lane
);

  // input register
  logic       in_valid_q;
  logic       in_mode_q;
  logic [1:0] in_lane_q;

  // controller state
  twdsc_pkg::ctl_t ctl_q, ctl_d;
  twdsc_pkg::ctl_t step1, step2;

  // result register
  logic        out_valid_q;
  logic [10:0] out_data_q;

  logic             out_free;
  logic             consume;
  logic             out_load;
  twdsc_pkg::lamps_t lamps;
  logic [2:0]       gates;
  logic [1:0]       serving;

  assign out_free = ~out_valid_q | m_axis_tready;

  // up to two phase changes per cycle; a chain of empty phases holds the tick until it ends
  assign step1 = (ctl_q.phase_left == 8'd0) ? twdsc_pkg::advance(ctl_q, cfg_i) : ctl_q;
  assign step2 = (step1.phase_left == 8'd0) ? twdsc_pkg::advance(step1, cfg_i) : step1;

  // lamps, gates and serving lane for this second
  always_comb begin
    lamps   = twdsc_pkg::lamps_now(step2);
    serving = twdsc_pkg::LANE_NONE;
    for (int i = 0; i < 3; i++) begin
      gates[i] = (lamps[i] == twdsc_pkg::LAMP_GREEN) ||
                 (lamps[i] == twdsc_pkg::LAMP_YELLOW &&
                  step2.prev_lamps[i] == twdsc_pkg::LAMP_GREEN);
    end
    for (int i = 2; i >= 0; i--) begin
      if (lamps[i] != twdsc_pkg::LAMP_RED) serving = 2'(i);
    end
  end

  // state update for the registered item
  always_comb begin
    ctl_d    = ctl_q;
    consume  = 1'b0;
    out_load = 1'b0;
    if (in_valid_q) begin
      if (in_mode_q == twdsc_pkg::MODE_PRESS) begin
        consume = 1'b1;
        if (in_lane_q != twdsc_pkg::LANE_NONE) begin
          ctl_d.pending    = ctl_q.pending | (3'b001 << in_lane_q);
          ctl_d.latest_req = in_lane_q;
        end
      end else begin
        ctl_d = step2;
        if (step2.phase_left != 8'd0 && out_free) begin
          consume          = 1'b1;
          out_load         = 1'b1;
          ctl_d.phase_left = step2.phase_left - 8'd1;
          if (ctl_d.phase_left == 8'd0) ctl_d.prev_lamps = lamps;
        end
      end
    end
  end

  assign s_axis_tready = ~in_valid_q | consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ctl_q       <= twdsc_pkg::CTL_RESET;
    end else begin
      ctl_q <= ctl_d;
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_mode_q <= s_axis_tuser;
      in_lane_q <= s_axis_tdata[1:0];
    end
    if (out_load) begin
      out_data_q <= {serving, gates, lamps};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_data_q};

endmodule

/* sv/three_way_demand_signal_controller.sv */
// channel   | dir | handshake        | tdata                           | tuser
// ----------+-----+------------------+---------------------------------+-----------
// s_axis    | in  | tvalid / tready  | [1:0] lane                      | [0] mode
// m_axis    | out | tvalid / tready  | lamps [5:0], gates [8:6], serv  | -
// apb       | in  | psel+penable     | regs at 0x0, 0x4, 0x8           | -
//
// one item per cycle unless a tick is held; a tick moves from the input register to the result register on m_axis
// the next-phase logic resolves two phase changes per cycle; a chain of empty
// phases (zero-valued registers) holds the tick in the input register until it ends
// reset: registers to 15/5/15, lane 0 green, no requests, outputs empty
// a stalled m_axis holds a tick in the input register and blocks items behind it
module three_way_demand_signal_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [1:0] lane, [7:2] zero
  input  logic                          s_axis_tuser,  // [0] mode
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [1:0] lamp_zero, [3:2] lamp_one, [5:4] lamp_two, [6] gate_zero,
  // [7] gate_one, [8] gate_two, [10:9] serving_lane, [15:11] zero
  output logic [15:0]                   m_axis_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [twdsc_pkg::PADDR_W-1:0] paddr,
  input  logic [twdsc_pkg::PDATA_W-1:0] pwdata,
  output logic [twdsc_pkg::PDATA_W-1:0] prdata,
  output logic                          pready
);

  twdsc_pkg::cfg_t cfg;

  twdsc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  twdsc_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

/* sv/twdsc_checker.sv */
module twdsc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [15:0]                   m_axis_tdata,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [twdsc_pkg::PADDR_W-1:0] paddr,
  input logic [twdsc_pkg::PDATA_W-1:0] pwdata,
  input logic [twdsc_pkg::PDATA_W-1:0] prdata,
  input logic                          pready
);

  logic       tick_in;
  logic       res_out;
  logic       apb_wr;
  logic [2:0] ticks_q;

  assign tick_in = s_axis_tvalid & s_axis_tready & (s_axis_tuser == twdsc_pkg::MODE_TICK);
  assign res_out = m_axis_tvalid & m_axis_tready;
  assign apb_wr  = psel & penable & pwrite & pready;

  // ticks accepted but not yet delivered as results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= 3'd0;
    end else begin
      ticks_q <= ticks_q + {2'd0, tick_in} - {2'd0, res_out};
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // every result comes from a tick
  a_res_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_out |-> ticks_q != 3'd0)
    else $error("result without a tick");

  // at most the input and result registers hold ticks
  a_ticks_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ticks_q <= 3'd2)
    else $error("too many ticks in flight");

  // a written register reads back
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    apb_wr && paddr[3:2] != twdsc_pkg::REG_UNUSED ##1
      !apb_wr && paddr[3:2] == $past(paddr[3:2])
      |-> prdata[7:0] == $past(pwdata[7:0]))
    else $error("register read back mismatch");

  // unused register bits read zero after a write
  a_cfg_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(apb_wr) |-> prdata[twdsc_pkg::PDATA_W-1:8] == '0)
    else $error("upper register bits not zero");

endmodule

bind three_way_demand_signal_controller twdsc_checker u_twdsc_checker (.*);
